/* hw/rtl/format_value_in_radix_core_defines.svh */
// ----------------------------------------------------------------------------
// format_value_in_radix_core_defines
// Assertion macros shared by the radix formatter RTL.
// ----------------------------------------------------------------------------
`ifndef FORMAT_VALUE_IN_RADIX_CORE_DEFINES_SVH
`define FORMAT_VALUE_IN_RADIX_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define FVR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define FVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fvr_pkg.sv */
// ----------------------------------------------------------------------------
// fvr_pkg
// Types and constants shared by the radix formatter modules.
// ----------------------------------------------------------------------------
package fvr_pkg;

    localparam int INT_BITS   = 24;
    localparam int FRAC_BITS  = 24;
    localparam int VAL_W      = INT_BITS + FRAC_BITS + 1;
    localparam int MAX_RES    = 64;
    localparam int FRAC_LIM   = 38;
    localparam int CNT_W      = $clog2(INT_BITS + 1);
    localparam int PTR_W      = $clog2(INT_BITS);
    localparam int CHAR_CNT_W = $clog2(MAX_RES + 1);

    localparam logic [6:0] CH_DIGIT  = 7'd48;
    localparam logic [6:0] CH_LETTER = 7'd55;
    localparam logic [6:0] CH_DOT    = 7'd46;
    localparam logic [6:0] CH_MINUS  = 7'd45;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    // Classified request handed from front to back
    typedef struct packed {
        logic                 neg;
        logic [INT_BITS-1:0]  int_part;
        logic [FRAC_BITS-1:0] frac_part;
    } fvr_req_t;

    function automatic logic [6:0] digit_char(input logic [5:0] d);
        digit_char = (d <= 6'd9) ? (7'(d) + CH_DIGIT) : (7'(d) + CH_LETTER);
    endfunction

endpackage

/* hw/rtl/fvr_front.sv */
// ----------------------------------------------------------------------------
// fvr_front
// Accepts values, takes the magnitude and splits integer and fraction parts.
// ----------------------------------------------------------------------------
module fvr_front
    import fvr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VAL_W-1:0] s_value,
    output logic                    q_valid,
    input  logic                    q_ready,
    output fvr_req_t                q_data
);

    logic [VAL_W-1:0]   neg_val;
    logic [VAL_W-2:0]   mag;
    logic               neg;
    fvr_req_t           req;

    // Magnitude with saturation of the most negative pattern
    always_comb begin
        neg     = s_value[VAL_W-1];
        neg_val = VAL_W'(0) - VAL_W'(s_value);
        if (!neg)
            mag = s_value[VAL_W-2:0];
        else if (neg_val[VAL_W-1])
            mag = '1;
        else
            mag = neg_val[VAL_W-2:0];
        req.neg       = neg && (mag != '0);
        req.int_part  = mag[VAL_W-2:FRAC_BITS];
        req.frac_part = mag[FRAC_BITS-1:0];
    end

    // Two-entry queue toward the back end
    fvr_req_t     fifo_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic         push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push)
            fifo_reg[wr_ptr_reg] <= req;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* hw/rtl/fvr_back.sv */
// ----------------------------------------------------------------------------
// fvr_back
// Divides out integer digits, stacks them, then emits text and fraction.
// ----------------------------------------------------------------------------
module fvr_back
    import fvr_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  fvr_req_t       q_data,
    input  logic [5:0]     base,
    input  logic [5:0]     limit,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [6:0]     m_text_char,
    output logic           m_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_DIGIT, S_SIGN, S_POP, S_DOT, S_MUL
    } state_t;

    state_t                state_reg;
    logic                  neg_reg;
    logic [INT_BITS-1:0]   quo_reg;
    logic [5:0]            rem_reg;
    logic [$clog2(INT_BITS+1)-1:0] bit_reg;
    logic [FRAC_BITS-1:0]  frac_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CHAR_CNT_W-1:0] nchar_reg;
    logic [5:0]            fcnt_reg;
    logic [5:0]            cap_reg;
    logic [5:0]            stack_mem [INT_BITS];
    logic [5:0]            rd_data_reg;
    logic                  out_full;
    logic                  emit;

    // Shift-subtract step of the restoring divider
    logic [6:0] trial;
    logic [6:0] diff;
    assign trial = {rem_reg, quo_reg[INT_BITS-1]};
    assign diff  = trial - {1'b0, base};

    // Fraction multiply by the base
    logic [FRAC_BITS+5:0] prod;
    assign prod = FRAC_BITS'(0) + ({6'd0, frac_reg} * {{FRAC_BITS{1'b0}}, base});

    // Room for fraction digits after the dot
    logic [CHAR_CNT_W:0] room;
    logic [5:0]          cap;
    always_comb begin
        room = (CHAR_CNT_W+1)'(MAX_RES - 1) - {1'b0, nchar_reg};
        if ((CHAR_CNT_W+1)'(limit) < room) cap = limit;
        else cap = 6'(room);
    end

    assign out_full = m_valid && !m_ready;
    assign q_ready  = (state_reg == S_IDLE);

    // A character is loaded into the output register this cycle
    assign emit = !out_full && (((state_reg == S_SIGN) && neg_reg) ||
                                (state_reg == S_POP) || (state_reg == S_DOT) ||
                                (state_reg == S_MUL));

    logic [PTR_W-1:0] top_idx;
    assign top_idx = PTR_W'(cnt_reg - CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (state_reg == S_DIGIT)
            stack_mem[PTR_W'(cnt_reg)] <= rem_reg;
        rd_data_reg <= stack_mem[top_idx];
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid   <= 1'b0;
        end else begin
            if (emit) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        neg_reg   <= q_data.neg;
                        quo_reg   <= q_data.int_part;
                        frac_reg  <= q_data.frac_part;
                        rem_reg   <= '0;
                        bit_reg   <= '0;
                        cnt_reg   <= '0;
                        nchar_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                // One quotient bit per cycle
                S_DIV: begin
                    if (diff[6]) begin
                        rem_reg <= trial[5:0];
                        quo_reg <= {quo_reg[INT_BITS-2:0], 1'b0};
                    end else begin
                        rem_reg <= diff[5:0];
                        quo_reg <= {quo_reg[INT_BITS-2:0], 1'b1};
                    end
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == ($clog2(INT_BITS+1))'(INT_BITS - 1))
                        state_reg <= S_DIGIT;
                end
                // Push remainder, decide whether to keep dividing
                S_DIGIT: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    rem_reg <= '0;
                    bit_reg <= '0;
                    if (quo_reg != '0 && cnt_reg != CNT_W'(INT_BITS - 1))
                        state_reg <= S_DIV;
                    else
                        state_reg <= S_SIGN;
                end
                // Sign once, then this state is the stack read step for each digit
                S_SIGN: begin
                    if (!out_full) begin
                        if (neg_reg) begin
                            m_text_char <= CH_MINUS;
                            m_last      <= 1'b0;
                            nchar_reg   <= nchar_reg + 1'b1;
                            neg_reg     <= 1'b0;
                        end
                        state_reg <= S_POP;
                    end
                end
                // rd_data_reg holds the top entry here
                S_POP: begin
                    if (!out_full) begin
                        m_text_char <= digit_char(rd_data_reg);
                        nchar_reg   <= nchar_reg + 1'b1;
                        cnt_reg     <= cnt_reg - 1'b1;
                        if (cnt_reg == CNT_W'(1)) begin
                            m_last    <= (frac_reg == '0) || (cap == 6'd0);
                            state_reg <= ((frac_reg == '0) || (cap == 6'd0))
                                         ? S_IDLE : S_DOT;
                        end else begin
                            m_last    <= 1'b0;
                            state_reg <= S_SIGN;
                        end
                    end
                end
                S_DOT: begin
                    if (!out_full) begin
                        m_text_char <= CH_DOT;
                        m_last      <= 1'b0;
                        cap_reg     <= cap;
                        fcnt_reg    <= '0;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!out_full) begin
                        m_text_char <= digit_char(prod[FRAC_BITS+5:FRAC_BITS]);
                        frac_reg    <= prod[FRAC_BITS-1:0];
                        fcnt_reg    <= fcnt_reg + 1'b1;
                        if (prod[FRAC_BITS-1:0] == '0 || fcnt_reg + 1'b1 == cap_reg) begin
                            m_last    <= 1'b1;
                            state_reg <= S_IDLE;
                        end else begin
                            m_last    <= 1'b0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/format_value_in_radix_core.sv */
// ----------------------------------------------------------------------------
// format_value_in_radix_core
// Formats a signed Q24.24 value as ASCII text in a base from 2 to 36.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals
// s_       in         s_valid s_ready s_value
// m_       out        m_valid m_ready m_text_char m_last
// cfg_     in         cfg_valid cfg_ready cfg_index cfg_data
//
// Each integer digit is found by the bit-serial divider (one S_DIV step per quotient bit, then a push).
// Each integer digit is emitted as a stack read step and an output step, the '-'
// rides in the read step; the dot and each fraction digit take one step each.
// A stalled output holds the back end in its character-emitting states.
// Synchronous active-low reset clears control; the queue holds two values.
// ----------------------------------------------------------------------------
`include "format_value_in_radix_core_defines.svh"

module format_value_in_radix_core
    import fvr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VAL_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [6:0]              m_text_char,
    output logic                    m_last,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic [5:0]              cfg_data
);

    logic [5:0] base_reg, limit_reg, base_eff, limit_eff;
    logic       q_valid, q_ready;
    fvr_req_t   q_data;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= 6'd10;
            limit_reg <= 6'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BASE:  base_reg  <= cfg_data;
                CFG_LIMIT: limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp to supported ranges
    assign base_eff  = (base_reg < 6'd2) ? 6'd2 : ((base_reg > 6'd36) ? 6'd36 : base_reg);
    assign limit_eff = (limit_reg > 6'(FRAC_LIM)) ? 6'(FRAC_LIM) : limit_reg;

    fvr_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_value,
        .q_valid, .q_ready, .q_data
    );

    fvr_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .base(base_eff), .limit(limit_eff),
        .m_valid, .m_ready, .m_text_char, .m_last
    );

    `FVR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_text_char), "stalled output changed")
    `FVR_ASSERT_IMP(a_base_range, 1'b1, base_eff >= 6'd2 && base_eff <= 6'd36, "base out of range")
    `FVR_ASSERT_IMP(a_take_idle, q_valid && q_ready, !m_valid || m_last, "back took request mid-text")

endmodule
